// File: rtl/flowtbl_pkg.sv
// Shared constants, types and helpers for the IPv4 five-tuple flow table.
// No dependencies; every other file in rtl/ imports this package.
package flowtbl_pkg;

    localparam int DEF_MAX_FLOWS   = 1024;
    localparam int DEF_NUM_BUCKETS = 512;

    localparam int SIZE_W    = 16;
    localparam int HLEN_W    = 4;
    localparam int FRAG_W    = 13;
    localparam int ADDR_W    = 32;
    localparam int PROTO_W   = 8;
    localparam int PORT_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int FLOW_ID_W = 10;
    localparam int BUCKET_W  = 9;
    localparam int SUM_W     = 32;

    localparam logic [SIZE_W-1:0]  MIN_IP_SIZE = 16'd20;
    localparam logic [FRAG_W-1:0]  FRAG_MASK   = 13'h1FFF;
    localparam logic [PROTO_W-1:0] PROTO_TCP   = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP   = 8'd17;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_EXISTING = 2'd0,
        STATUS_NEW      = 2'd1,
        STATUS_REJECTED = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    // canonical tuple: lower address side first
    typedef struct packed {
        logic [ADDR_W-1:0]  lo_addr;
        logic [ADDR_W-1:0]  hi_addr;
        logic [PORT_W-1:0]  lo_port;
        logic [PORT_W-1:0]  hi_port;
        logic [PROTO_W-1:0] proto;
    } tuple_t;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: rtl/flowtbl_pkt_if.sv
// Request channel carrying one packet's IPv4 header fields.
// Depends on flowtbl_pkg.
interface flowtbl_pkt_if import flowtbl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SIZE_W-1:0]   ip_size;
    logic [HLEN_W-1:0]   header_words;
    logic [SIZE_W-1:0]   total_length;
    logic [FRAG_W-1:0]   fragment_offset;
    logic [ADDR_W-1:0]   source_address;
    logic [ADDR_W-1:0]   destination_address;
    logic [PROTO_W-1:0]  l4_protocol;
    logic [PORT_W-1:0]   source_port;
    logic [PORT_W-1:0]   destination_port;

    modport source (
        output valid, ip_size, header_words, total_length, fragment_offset,
               source_address, destination_address, l4_protocol,
               source_port, destination_port,
        input  ready
    );
    modport sink (
        input  valid, ip_size, header_words, total_length, fragment_offset,
               source_address, destination_address, l4_protocol,
               source_port, destination_port,
        output ready
    );
endinterface

// File: rtl/flowtbl_res_if.sv
// Result channel: lookup status, flow id, bucket and protocol per request.
// Depends on flowtbl_pkg.
interface flowtbl_res_if import flowtbl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  lookup_status;
    logic [FLOW_ID_W-1:0] flow_id;
    logic [BUCKET_W-1:0]  bucket;
    logic [PROTO_W-1:0]   protocol_echo;

    modport source (
        output valid, lookup_status, flow_id, bucket, protocol_echo,
        input  ready
    );
    modport sink (
        input  valid, lookup_status, flow_id, bucket, protocol_echo,
        output ready
    );
endinterface

// File: rtl/flowtbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on flowtbl_pkg (idx_width).
module flowtbl_ram import flowtbl_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = idx_width(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/flowtbl_hash.sv
// Iterative tuple hash: 32-bit wrapping sum over one shared adder, then the
// remainder by NUM_BUCKETS through a reciprocal multiply on one shared
// multiplier and a single compare/subtract correction. Depends on flowtbl_pkg.
module flowtbl_hash import flowtbl_pkg::*; #(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    localparam int BW         = idx_width(NUM_BUCKETS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tuple_t        tuple,
    output logic          done,
    output logic [BW-1:0] bucket
);

    localparam int CNT_W  = 3;
    localparam int PROD_W = 2 * SUM_W;

    localparam logic [CNT_W-1:0] STEP_HI_ADDR = 3'd0;
    localparam logic [CNT_W-1:0] STEP_PROTO   = 3'd1;
    localparam logic [CNT_W-1:0] STEP_LO_PORT = 3'd2;
    localparam logic [CNT_W-1:0] STEP_HI_PORT = 3'd3;
    localparam logic [CNT_W-1:0] STEP_QUOT    = 3'd4;
    localparam logic [CNT_W-1:0] STEP_BACK    = 3'd5;
    localparam logic [CNT_W-1:0] STEP_SUB     = 3'd6;
    localparam logic [CNT_W-1:0] STEP_FIX     = 3'd7;

    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(NUM_BUCKETS);
    // floor(2^32 / NUM_BUCKETS); all ones for a single bucket.
    // The estimated quotient is then low by at most one.
    localparam logic [SUM_W-1:0] RECIP = (NUM_BUCKETS > 1)
        ? SUM_W'((64'd1 << SUM_W) / 64'(NUM_BUCKETS)) : {SUM_W{1'b1}};

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] quo_reg, quo_next;

    logic [SUM_W-1:0]  addend;
    logic              carry_in;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  mul_a;
    logic [SUM_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        addend   = '0;
        carry_in = 1'b0;
        mul_a    = acc_reg;
        mul_b    = RECIP;
        case (cnt_reg)
            STEP_HI_ADDR: addend = tuple.hi_addr;
            STEP_PROTO:   addend = SUM_W'(tuple.proto);
            STEP_LO_PORT: addend = SUM_W'(tuple.lo_port);
            STEP_HI_PORT: addend = SUM_W'(tuple.hi_port);
            STEP_QUOT:
            begin
                mul_a = acc_reg;
                mul_b = RECIP;
            end
            STEP_BACK:
            begin
                mul_a = quo_reg;
                mul_b = DIVISOR;
            end
            STEP_SUB:
            begin
                addend   = ~quo_reg;
                carry_in = 1'b1;
            end
            default:
            begin
                addend   = ~DIVISOR;
                carry_in = 1'b1;
            end
        endcase
        sum  = acc_reg + addend + SUM_W'(carry_in);
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = tuple.lo_addr;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == STEP_QUOT)
            begin
                quo_next = prod[PROD_W-1:SUM_W];
            end
            else if (cnt_reg == STEP_BACK)
            begin
                quo_next = prod[SUM_W-1:0];
            end
            else if (cnt_reg == STEP_FIX)
            begin
                // remainder estimate is below twice the divisor
                if (acc_reg >= DIVISOR)
                begin
                    acc_next = sum;
                end
            end
            else
            begin
                acc_next = sum;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_FIX)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

    assign done   = done_reg;
    assign bucket = acc_reg[BW-1:0];

endmodule

// File: rtl/ipv4_five_tuple_flow_table_core.sv
// Top level of the IPv4 five-tuple flow table: header checks, tuple ordering,
// bucket chain walk and insertion. Depends on flowtbl_pkg, flowtbl_pkt_if,
// flowtbl_res_if, flowtbl_ram and flowtbl_hash.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------
//  pkt     | in  | valid/ready | ip_size .. destination_port (header fields)
//  res     | out | valid/ready | lookup_status, flow_id, bucket, protocol_echo
//
// One request at a time; pkt.ready is high only while the sequencer is idle.
// A rejected header goes straight to the result. Otherwise the sequencer
// runs the shared hash unit (start, 4 adds, 2 multiplies, subtract,
// correction, done), reads the bucket head, then walks the bucket chain with
// one registered RAM read per entry until a hit or the insert step.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer stalls at the end only if the register is still full.
// Reset clears the flow count and control; the RAMs need no clearing pass.
module ipv4_five_tuple_flow_table_core import flowtbl_pkg::*; #(
    parameter int MAX_FLOWS   = DEF_MAX_FLOWS,
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
    input  logic          clk,
    input  logic          rst_n,
    flowtbl_pkt_if.sink   pkt,
    flowtbl_res_if.source res
);

    localparam int IW      = idx_width(MAX_FLOWS);
    localparam int CW      = $clog2(MAX_FLOWS + 1);
    localparam int BW      = idx_width(NUM_BUCKETS);
    localparam int TUPLE_W = $bits(tuple_t);
    localparam int EW      = TUPLE_W + BW + IW + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_FLOWS);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_HASH     = 8'b0000_0010,
        ST_HEAD_RD  = 8'b0000_0100,
        ST_HEAD_CHK = 8'b0000_1000,
        ST_ENT_RD   = 8'b0001_0000,
        ST_ENT_CHK  = 8'b0010_0000,
        ST_INSERT   = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     flows_in_use_reg, flows_in_use_next;
    logic              hash_start_reg, hash_start_next;
    tuple_t            tuple_reg, tuple_next;
    logic [BW-1:0]     bucket_reg, bucket_next;
    logic [IW-1:0]     ptr_reg, ptr_next;
    logic [IW-1:0]     head_ptr_reg, head_ptr_next;
    logic              head_valid_reg, head_valid_next;
    status_t           rs_status_reg, rs_status_next;
    logic [IW-1:0]     rs_id_reg, rs_id_next;

    logic                 res_valid_reg, res_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [FLOW_ID_W-1:0] out_id_reg, out_id_next;
    logic [BUCKET_W-1:0]  out_bucket_reg, out_bucket_next;
    logic [PROTO_W-1:0]   out_proto_reg, out_proto_next;

    // request decode
    logic              accept;
    logic              reject;
    logic              ports_on;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
    tuple_t            canon;

    // hash unit
    logic              hash_done;
    logic [BW-1:0]     hash_bucket;

    // RAM ports
    logic              head_we;
    logic [IW-1:0]     head_rdata;
    logic              ent_we;
    logic [EW-1:0]     ent_wdata;
    logic [EW-1:0]     ent_rdata;
    tuple_t            ent_tuple;
    logic [BW-1:0]     ent_bkt;
    logic [IW-1:0]     ent_nxt;
    logic              ent_nv;

    logic              slot_free;
    logic [31:0]       id_wide;
    logic [31:0]       bucket_wide;

    assign accept   = pkt.valid && pkt.ready;
    assign reject   = (pkt.ip_size < MIN_IP_SIZE)
                   || (SIZE_W'({pkt.header_words, 2'b00}) > pkt.ip_size)
                   || (pkt.ip_size < pkt.total_length)
                   || ((pkt.fragment_offset & FRAG_MASK) != '0);
    assign ports_on = (pkt.l4_protocol == PROTO_TCP) || (pkt.l4_protocol == PROTO_UDP);
    assign sport    = ports_on ? pkt.source_port : '0;
    assign dport    = ports_on ? pkt.destination_port : '0;

    // equal addresses: destination side counts as lower
    always_comb
    begin
        canon.proto = pkt.l4_protocol;
        if (pkt.source_address < pkt.destination_address)
        begin
            canon.lo_addr = pkt.source_address;
            canon.hi_addr = pkt.destination_address;
            canon.lo_port = sport;
            canon.hi_port = dport;
        end
        else
        begin
            canon.lo_addr = pkt.destination_address;
            canon.hi_addr = pkt.source_address;
            canon.lo_port = dport;
            canon.hi_port = sport;
        end
    end

    flowtbl_hash #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start_reg),
        .tuple  (tuple_reg),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // bucket heads: index of the newest entry in each bucket
    flowtbl_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (bucket_reg),
        .wdata (flows_in_use_reg[IW-1:0]),
        .raddr (bucket_reg),
        .rdata (head_rdata)
    );

    // entries: tuple, bucket, chain link and link-valid bit
    flowtbl_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FLOWS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (flows_in_use_reg[IW-1:0]),
        .wdata (ent_wdata),
        .raddr (ptr_reg),
        .rdata (ent_rdata)
    );

    assign ent_wdata = {tuple_reg, bucket_reg, head_ptr_reg, head_valid_reg};
    assign ent_tuple = ent_rdata[EW-1 -: TUPLE_W];
    assign ent_bkt   = ent_rdata[IW+1 +: BW];
    assign ent_nxt   = ent_rdata[1 +: IW];
    assign ent_nv    = ent_rdata[0];

    assign slot_free   = !res_valid_reg || res.ready;
    assign id_wide     = 32'(rs_id_reg);
    assign bucket_wide = 32'(bucket_reg);

    always_comb
    begin
        state_next        = state_reg;
        flows_in_use_next = flows_in_use_reg;
        hash_start_next   = 1'b0;
        tuple_next        = tuple_reg;
        bucket_next       = bucket_reg;
        ptr_next          = ptr_reg;
        head_ptr_next     = head_ptr_reg;
        head_valid_next   = head_valid_reg;
        rs_status_next    = rs_status_reg;
        rs_id_next        = rs_id_reg;
        head_we           = 1'b0;
        ent_we            = 1'b0;

        res_valid_next  = res_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_bucket_next = out_bucket_reg;
        out_proto_next  = out_proto_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tuple_next = canon;
                    rs_id_next = '0;
                    if (reject)
                    begin
                        rs_status_next = STATUS_REJECTED;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        hash_start_next = 1'b1;
                        state_next      = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    state_next  = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                // a head at or beyond the fill count was never written
                head_ptr_next = head_rdata;
                ptr_next      = head_rdata;
                if (CW'(head_rdata) < flows_in_use_reg)
                begin
                    head_valid_next = 1'b1;
                    state_next      = ST_ENT_RD;
                end
                else
                begin
                    head_valid_next = 1'b0;
                    state_next      = ST_INSERT;
                end
            end
            ST_ENT_RD:
            begin
                state_next = ST_ENT_CHK;
            end
            ST_ENT_CHK:
            begin
                // stale head pointing into another bucket: bucket is empty
                if (ent_bkt != bucket_reg)
                begin
                    head_valid_next = 1'b0;
                    state_next      = ST_INSERT;
                end
                else if (ent_tuple == tuple_reg)
                begin
                    rs_status_next = STATUS_EXISTING;
                    rs_id_next     = ptr_reg;
                    state_next     = ST_DONE;
                end
                else if (ent_nv)
                begin
                    ptr_next   = ent_nxt;
                    state_next = ST_ENT_RD;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (flows_in_use_reg == FULL_COUNT)
                begin
                    rs_status_next = STATUS_FULL;
                    rs_id_next     = '0;
                end
                else
                begin
                    ent_we            = 1'b1;
                    head_we           = 1'b1;
                    rs_status_next    = STATUS_NEW;
                    rs_id_next        = flows_in_use_reg[IW-1:0];
                    flows_in_use_next = flows_in_use_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    out_status_next = rs_status_reg;
                    out_id_next     = id_wide[FLOW_ID_W-1:0];
                    if (rs_status_reg == STATUS_REJECTED)
                    begin
                        out_bucket_next = '0;
                        out_proto_next  = '0;
                    end
                    else
                    begin
                        out_bucket_next = bucket_wide[BUCKET_W-1:0];
                        out_proto_next  = tuple_reg.proto;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            flows_in_use_reg <= '0;
            hash_start_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            flows_in_use_reg <= flows_in_use_next;
            hash_start_reg   <= hash_start_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tuple_reg      <= tuple_next;
        bucket_reg     <= bucket_next;
        ptr_reg        <= ptr_next;
        head_ptr_reg   <= head_ptr_next;
        head_valid_reg <= head_valid_next;
        rs_status_reg  <= rs_status_next;
        rs_id_reg      <= rs_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_bucket_reg <= out_bucket_next;
        out_proto_reg  <= out_proto_next;
    end

    assign pkt.ready         = (state_reg == ST_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.lookup_status = out_status_reg;
    assign res.flow_id       = out_id_reg;
    assign res.bucket        = out_bucket_reg;
    assign res.protocol_echo = out_proto_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flows_in_use_reg <= FULL_COUNT)
        else $error("flow count above table size");

    a_insert_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) && (flows_in_use_reg != FULL_COUNT)
        |=> flows_in_use_reg == CW'($past(flows_in_use_reg) + 1'b1))
        else $error("insert did not advance flow count");

    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == ST_HASH)
        else $error("hash finished outside hash wait");

    a_reject_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.lookup_status == STATUS_REJECTED)
        |-> (res.flow_id == '0) && (res.bucket == '0) && (res.protocol_echo == '0))
        else $error("rejected request carries nonzero fields");

endmodule
